/* sv/mhkn_pkg.sv */
package mhkn_pkg;

  // Key size in bytes; the key carries two modhex characters per byte
  localparam int KEY_BYTES  = 32;
  localparam int PLAIN_LEN  = 2 * KEY_BYTES;
  localparam int DASHED_LEN = 2 * KEY_BYTES + (2 * KEY_BYTES - 1) / 8;

  // Position counter: wide enough for the dashed length at the largest key
  localparam int POS_W   = 8;
  localparam int MODE_POS = 8;   // the character here fixes the format
  localparam int GROUP_W = 4;    // position within a group of nine
  localparam int DASH_SLOT = 8;  // last place of a group of nine holds the dash

  localparam logic [7:0] DASH_CHAR = 8'h2D;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    MODE_UNDECIDED,
    MODE_PLAIN,
    MODE_DASHED
  } mode_t;

  // One queue entry: a character, its last and error flags, plus a request for a trailing dash
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       err;
    logic       add_dash;
  } entry_t;

  localparam logic [7:0] MH_ALPHA [16] = '{
    8'h63, 8'h62, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69,
    8'h6A, 8'h6B, 8'h6C, 8'h6E, 8'h72, 8'h74, 8'h75, 8'h76
  };

  // True for a modhex letter in either case
  function automatic logic mh_is_modhex(logic [7:0] c);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 16; i++) begin
      if (c == MH_ALPHA[i] || c == (MH_ALPHA[i] - 8'd32)) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

/* sv/modhex_key_normalizer.sv */
// Modhex recovery key normalizer.
// Input channel: one ASCII character per transaction (in_char, in_last),
// taken when push is high and full is low. in_last marks the end of a key.
// Result channel: the oldest result sits on out_char/out_last/key_error
// while empty is low; it is taken when pop is high and empty is low.
// Each modhex character comes out in lower case; a dash follows every group
// of eight but the last. Dashes of the input are consumed, not forwarded.
// The final result carries out_last and key_error; on error out_char is zero
// and the consumer drops the key's earlier results.
// Path: a taken character enters the queue, then the output register; a
// trailing dash goes out from the output register after it. Input takes one
// character per cycle while full is low; the output register emits one result
// per cycle while pop is high, so a dash at a group end delays the next character.
// A four-entry queue between the checker and the output stage absorbs
// stalls; when the receiver holds off pop, the queue fills and full rises.
// Reset (synchronous) empties the queue and output and starts a new key.
module modhex_key_normalizer import mhkn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_char,
  input  logic       in_last,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic       out_last,
  output logic       key_error
);

  entry_t wr_entry;
  entry_t rd_entry;
  logic   q_push;
  logic   q_pop;
  logic   q_full;
  logic   q_empty;

  assign full = q_full;

  // Character checking and state tracking
  mhkn_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (push),
    .in_char  (in_char),
    .in_last  (in_last),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (wr_entry)
  );

  // Decoupling queue
  mhkn_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (wr_entry),
    .full     (q_full),
    .pop      (q_pop),
    .rd_entry (rd_entry),
    .empty    (q_empty)
  );

  // Result emission with dash insertion
  mhkn_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (!q_empty),
    .q_entry   (rd_entry),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .out_char  (out_char),
    .out_last  (out_last),
    .key_error (key_error)
  );

endmodule

/* sv/mhkn_front.sv */
module mhkn_front import mhkn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_char,
  input  logic       in_last,
  input  logic       q_full,
  output logic       q_push,
  output entry_t     q_entry
);

  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   mcnt;
  logic [GROUP_W-1:0] slot;
  mode_t              mode;
  logic               err_seen;

  logic               accept;
  mode_t              mode_eff;
  logic               dashed;
  logic               dash_slot;
  logic               is_mh;
  logic               hit;
  logic               bad;
  logic               err_next;
  logic               final_err;
  logic [POS_W-1:0]   len;
  logic [POS_W-1:0]   m;
  logic [POS_W:0]     pos_inc;
  logic [POS_W:0]     m_inc;
  logic [7:0]         lower;

  assign accept = in_valid && !q_full;

  // Classify the incoming character against the current position and format
  always_comb begin
    mode_eff = mode;
    if (pos == POS_W'(MODE_POS) && mode == MODE_UNDECIDED) begin
      mode_eff = (in_char == DASH_CHAR) ? MODE_DASHED : MODE_PLAIN;
    end
    dashed    = (mode_eff == MODE_DASHED);
    dash_slot = dashed && (slot == GROUP_W'(DASH_SLOT));
    len       = dashed ? POS_W'(DASHED_LEN) : POS_W'(PLAIN_LEN);
    is_mh     = mh_is_modhex(in_char);
    hit       = !dash_slot && is_mh;
    bad       = dash_slot ? (in_char != DASH_CHAR) : !is_mh;
    err_next  = err_seen || (pos >= len) || bad;
    pos_inc   = {1'b0, pos} + 1'b1;
    final_err = err_next || (pos_inc != {1'b0, len}) || !hit;
    m         = dashed ? mcnt : pos;
    m_inc     = {1'b0, m} + 1'b1;
    lower     = in_char | 8'h20;
  end

  // Build the queue entry; a final character always pushes, while errored or silent ones before it push nothing
  always_comb begin
    q_entry = '0;
    q_push  = 1'b0;
    if (in_last) begin
      q_push        = accept;
      q_entry.ch    = final_err ? 8'h00 : lower;
      q_entry.last  = 1'b1;
      q_entry.err   = final_err;
    end else begin
      q_push           = accept && !err_next && hit;
      q_entry.ch       = lower;
      q_entry.add_dash = (m[2:0] == 3'd7) && (m_inc < (POS_W + 1)'(PLAIN_LEN));
    end
  end

  // Key state: position counters, format and sticky error
  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      mcnt     <= '0;
      slot     <= '0;
      mode     <= MODE_UNDECIDED;
      err_seen <= 1'b0;
    end else if (accept) begin
      if (in_last) begin
        pos      <= '0;
        mcnt     <= '0;
        slot     <= '0;
        mode     <= MODE_UNDECIDED;
        err_seen <= 1'b0;
      end else begin
        mode     <= mode_eff;
        err_seen <= err_next;
        if (pos != {POS_W{1'b1}}) begin
          pos  <= pos_inc[POS_W-1:0];
          slot <= (slot == GROUP_W'(DASH_SLOT)) ? '0 : slot + 1'b1;
          if (slot != GROUP_W'(DASH_SLOT)) mcnt <= mcnt + 1'b1;
        end
      end
    end
  end

endmodule

/* sv/mhkn_queue.sv */
module mhkn_queue import mhkn_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wr_entry,
  output logic   full,
  input  logic   pop,
  output entry_t rd_entry,
  output logic   empty
);

  entry_t              slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full     = (count == QCNT_W'(QDEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign rd_entry = slots[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= wr_entry;
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (!do_push && do_pop) count <= count - 1'b1;
    end
  end

endmodule

/* sv/mhkn_back.sv */
module mhkn_back import mhkn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  entry_t     q_entry,
  output logic       q_pop,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic       out_last,
  output logic       key_error
);

  logic out_valid;
  logic dash_pend;
  logic load;

  assign empty = !out_valid;
  assign load  = !out_valid || pop;
  assign q_pop = load && !dash_pend && q_valid;

  // Output register; a pending dash goes out before the next queue entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      dash_pend <= 1'b0;
    end else if (load) begin
      if (dash_pend) begin
        out_valid <= 1'b1;
        dash_pend <= 1'b0;
        out_char  <= DASH_CHAR;
        out_last  <= 1'b0;
        key_error <= 1'b0;
      end else if (q_valid) begin
        out_valid <= 1'b1;
        dash_pend <= q_entry.add_dash;
        out_char  <= q_entry.ch;
        out_last  <= q_entry.last;
        key_error <= q_entry.err;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* verif/tb_modhex_key_normalizer.sv */
`timescale 1ns / 1ps

module tb_modhex_key_normalizer;
  import mhkn_pkg::*;

  localparam int KEY_ITEMS    = 1950;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_REPORTS  = 10;

  // Lowercase modhex alphabet, in digit order
  localparam logic [7:0] LOWER_SET [16] = '{
    "c", "b", "d", "e", "f", "g", "h", "i",
    "j", "k", "l", "n", "r", "t", "u", "v"
  };

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       err;
  } norm_res_t;

  // One directed row; fixed marks a result typed in by hand
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       fixed;
    norm_res_t  res;
  } stim_row_t;

  localparam norm_res_t NO_RES    = '0;
  localparam norm_res_t ERR_FINAL = '{8'h00, 1'b1, 1'b1};

  localparam stim_row_t DIR_TAB [19] = '{
    // extremes of the character, each ending a one-character key
    '{8'h00, 1'b1, 1'b1, ERR_FINAL},
    '{8'hFF, 1'b1, 1'b1, ERR_FINAL},
    // good letter, but the key is far too short
    '{"V",   1'b1, 1'b1, ERR_FINAL},
    // mixed case group; the eighth letter is followed by a dash
    '{"C",   1'b0, 1'b0, NO_RES},
    '{"b",   1'b0, 1'b0, NO_RES},
    '{"D",   1'b0, 1'b0, NO_RES},
    '{"e",   1'b0, 1'b0, NO_RES},
    '{"F",   1'b0, 1'b0, NO_RES},
    '{"g",   1'b0, 1'b0, NO_RES},
    '{"H",   1'b0, 1'b0, NO_RES},
    '{"i",   1'b0, 1'b0, NO_RES},
    // dash at the mode position selects the dashed form, consumed silently
    '{"-",   1'b0, 1'b0, NO_RES},
    '{"J",   1'b0, 1'b0, NO_RES},
    // dash off a dash slot, then silence until the final error
    '{"-",   1'b0, 1'b0, NO_RES},
    '{"k",   1'b0, 1'b0, NO_RES},
    '{"l",   1'b1, 1'b1, ERR_FINAL},
    // short key, mode still undecided, with a non-modhex letter
    '{"n",   1'b0, 1'b0, NO_RES},
    '{"x",   1'b0, 1'b0, NO_RES},
    '{"r",   1'b1, 1'b1, ERR_FINAL}
  };

  logic       clk;
  logic       rst     = 1'b1;
  logic       push    = 1'b0;
  logic       full;
  logic [7:0] in_char = 8'h00;
  logic       in_last = 1'b0;
  logic       empty;
  logic       pop     = 1'b0;
  logic [7:0] out_char;
  logic       out_last;
  logic       key_error;

  // Normalizer state mirror
  logic [7:0] key_pos  = '0;
  mode_t      key_mode = MODE_UNDECIDED;
  logic       key_bad  = 1'b0;

  norm_res_t  fresh_q [$];  // results of the latest character
  norm_res_t  norm_q [$];   // results still owed by the block
  logic [7:0] key_q [$];    // key being sent
  logic       calm = 1'b0;  // no idling on either side
  int         items_sent  = 0;
  int         bad_results = 0;

  modhex_key_normalizer DUT (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_char   (in_char),
    .in_last   (in_last),
    .empty     (empty),
    .pop       (pop),
    .out_char  (out_char),
    .out_last  (out_last),
    .key_error (key_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int letter_index(input logic [7:0] c);
    for (int i = 0; i < 16; i++) begin
      if (c == LOWER_SET[i] || c == LOWER_SET[i] - 8'd32) return i;
    end
    return -1;
  endfunction

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    c = LOWER_SET[$urandom_range(0, 15)];
    if ($urandom_range(0, 1) == 1) c = c - 8'd32;
    return c;
  endfunction

  // Advance the mirror by one character; its results land in fresh_q
  function automatic void normalize_char(input logic [7:0] c, input logic last);
    int   p;
    int   len;
    int   m;
    int   idx;
    logic dslot;
    fresh_q.delete();
    p   = int'(key_pos);
    idx = -1;
    if (p == MODE_POS && key_mode == MODE_UNDECIDED)
      key_mode = (c == DASH_CHAR) ? MODE_DASHED : MODE_PLAIN;
    dslot = (key_mode == MODE_DASHED) && (p % 9 == DASH_SLOT);
    len   = (key_mode == MODE_DASHED) ? DASHED_LEN : PLAIN_LEN;
    if (p >= len) key_bad = 1'b1;
    if (dslot) begin
      if (c != DASH_CHAR) key_bad = 1'b1;
    end else begin
      idx = letter_index(c);
      if (idx < 0) key_bad = 1'b1;
    end
    // index among the letters only, for dash insertion
    m = (key_mode == MODE_DASHED) ? p - p / 9 : p;
    if (last) begin
      if (p + 1 != len) key_bad = 1'b1;
      if (key_bad || idx < 0) fresh_q.push_back(ERR_FINAL);
      else fresh_q.push_back(norm_res_t'{LOWER_SET[idx], 1'b1, 1'b0});
      key_pos  = '0;
      key_mode = MODE_UNDECIDED;
      key_bad  = 1'b0;
    end else begin
      if (p < 255) key_pos = key_pos + 8'd1;
      if (!(key_bad || dslot || idx < 0)) begin
        fresh_q.push_back(norm_res_t'{LOWER_SET[idx], 1'b0, 1'b0});
        if (m % 8 == 7 && m + 1 < PLAIN_LEN)
          fresh_q.push_back(norm_res_t'{DASH_CHAR, 1'b0, 1'b0});
      end
    end
  endfunction

  // Push one character; record what it owes once the transaction is taken
  task automatic send_char(input logic [7:0] c, input logic last, input logic fixed,
                           input norm_res_t res);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push    <= 1'b1;
    in_char <= c;
    in_last <= last;
    do @(posedge clk); while (full);
    normalize_char(c, last);
    if (fixed) begin
      norm_q.push_back(res);
    end else begin
      foreach (fresh_q[i]) norm_q.push_back(fresh_q[i]);
    end
    items_sent++;
  endtask

  // Result side: random stalls, compare each transaction with the oldest owed result
  initial begin : result_side
    norm_res_t want;
    int        stall;
    wait (rst == 1'b0);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        @(negedge clk);
        pop <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      if (norm_q.size() == 0) begin
        bad_results++;
        if (bad_results <= MAX_REPORTS)
          $display("unexpected result: char %h last %b err %b", out_char, out_last, key_error);
      end else begin
        want = norm_q.pop_front();
        if (out_char !== want.ch || out_last !== want.last || key_error !== want.err) begin
          bad_results++;
          if (bad_results <= MAX_REPORTS)
            $display("mismatch: expected char %h last %b err %b, got char %h last %b err %b",
                     want.ch, want.last, want.err, out_char, out_last, key_error);
        end
      end
    end
  end

  initial begin : stimulus
    int   kind;
    int   pick;
    logic dashed;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed keys
    foreach (DIR_TAB[i]) send_char(DIR_TAB[i].ch, DIR_TAB[i].last, DIR_TAB[i].fixed,
                                   DIR_TAB[i].res);

    // random keys: mostly well formed, some with one fault, some short or noise
    while (items_sent < KEY_ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 15);
      dashed = 1'($urandom_range(0, 1));
      key_q.delete();
      if (kind <= 12) begin
        for (int i = 0; i < PLAIN_LEN; i++) begin
          key_q.push_back(rand_letter());
          if (dashed && i % 8 == 7 && i < PLAIN_LEN - 1) key_q.push_back(DASH_CHAR);
        end
        if (kind >= 9) begin
          pick = $urandom_range(1, key_q.size() - 1);
          case ($urandom_range(0, 4))
            0: begin
              key_q[pick] = 8'($urandom_range(0, 255));
            end
            1: begin
              key_q.delete(pick);
            end
            2: begin
              repeat ($urandom_range(1, 3)) key_q.push_back(rand_letter());
            end
            3: begin
              // missing dash in the dashed form, stray dash in the plain one
              if (dashed) key_q[9 * $urandom_range(1, 6) + DASH_SLOT] = rand_letter();
              else key_q.insert(pick, DASH_CHAR);
            end
            default: begin
              while (key_q.size() > pick) void'(key_q.pop_back());
            end
          endcase
        end
      end else if (kind == 13) begin
        repeat ($urandom_range(1, 12)) key_q.push_back(rand_letter());
      end else begin
        repeat ($urandom_range(1, 80))
          key_q.push_back(($urandom_range(0, 3) == 0) ? DASH_CHAR : 8'($urandom_range(0, 255)));
      end
      foreach (key_q[i]) send_char(key_q[i], i == key_q.size() - 1, 1'b0, NO_RES);
    end

    @(negedge clk);
    push <= 1'b0;
    calm = 1'b0;

    // drain, then allow for anything extra the block might emit
    while (norm_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_results == 0 && norm_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/mhkn_pkg.sv
sv/mhkn_front.sv
sv/mhkn_queue.sv
sv/mhkn_back.sv
sv/modhex_key_normalizer.sv
verif/tb_modhex_key_normalizer.sv
